/* src/sorted_key_table_assert.svh */
// Assertion macros for the sorted key table.
// Used by sorted_key_table.sv; expects clk and arst_n in scope.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SKT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_key_table: check failed");

// next-cycle implication, checked out of reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_key_table: check failed");

`endif

/* src/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// No dependencies; imported by sorted_key_table.sv.
`default_nettype none

package skt_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int KEY_W           = 16;
	localparam int SIZE_W          = 32;
	localparam int ENTRY_W         = KEY_W + SIZE_W;
	localparam int POS_W           = 5;
	localparam int COUNT_W         = 6;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_READ   = 3'd2,
		OP_SORT   = 3'd3,
		OP_CLEAR  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
	} entry_t;

endpackage

`default_nettype wire

/* src/skt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module skt_ram #(
	parameter int DATA_W = 48,
	parameter int DEPTH  = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/sorted_key_table.sv */
// Flow, transfer to done: one scan of count entries for add, clear and unused codes,
// with an S_READ step first for read; the scan reads one RAM entry a cycle for min/max.
// Sort and remove repeat such scans as bubble passes until one makes no swap
// (at most count passes, one below two entries); remove first shifts the tail.
// One command at a time; done pulses one cycle as busy falls, results are never stalled.
// Reset: count 0, descending order; RAM contents undefined, no clearing pass.
`default_nettype none
`include "sorted_key_table_assert.svh"

module sorted_key_table
	import skt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         opcode,
	input  wire logic [KEY_W-1:0]   entry_key,
	input  wire logic [SIZE_W-1:0]  entry_size,
	input  wire logic [POS_W-1:0]   position,
	output logic                    done,
	output logic [1:0]              status,
	output logic [KEY_W-1:0]        read_key,
	output logic [SIZE_W-1:0]       read_size,
	output logic [COUNT_W-1:0]      entry_count,
	output logic [KEY_W-1:0]        min_key,
	output logic [KEY_W-1:0]        max_key,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int PCW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_PASS,
		S_TAIL
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_idx_q;
	logic [AW-1:0]      idx_s1;
	logic               vld_s1;
	logic               sort_en_q;
	logic               swapped_q;
	logic               sort_desc_q;
	logic               done_q;
	status_t            status_q;
	logic [KEY_W-1:0]   rkey_q;
	logic [SIZE_W-1:0]  rsize_q;
	logic [KEY_W-1:0]   min_q;
	logic [KEY_W-1:0]   max_q;
	entry_t             carry_q;

	logic               accept;
	logic               full;
	logic               pos_ok;
	logic [PCW-1:0]     pos_ext;
	logic [CW-1:0]      last_cnt;
	logic               do_swap;
	logic               scan_end;
	entry_t             rd_entry;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	skt_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = start && !busy;
	assign full     = (cnt_q == CW'(TABLE_DEPTH));
	assign pos_ext  = PCW'(position);
	assign pos_ok   = (pos_ext < PCW'(cnt_q));
	assign last_cnt = cnt_q - CW'(1);
	assign rd_entry = entry_t'(ram_rdata);
	assign scan_end = !vld_s1 && (rd_idx_q == cnt_q);
	// carry is the entry bubbling right; keep it moving when out of order
	assign do_swap  = sort_desc_q ? (carry_q.key < rd_entry.key)
	                              : (carry_q.key > rd_entry.key);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = rd_idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = pos_ext[AW-1:0];
				if (accept && opcode_t'(opcode) == OP_ADD && !full) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[AW-1:0];
					ram_wdata = {entry_key, entry_size};
				end
			end
			S_SHIFT: begin
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 - AW'(1);
					ram_wdata = ram_rdata;
				end
			end
			S_PASS: begin
				if (vld_s1 && sort_en_q && idx_s1 != '0) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 - AW'(1);
					ram_wdata = do_swap ? ram_rdata : carry_q;
				end
			end
			S_TAIL: begin
				if (sort_en_q && cnt_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = last_cnt[AW-1:0];
					ram_wdata = carry_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			sort_en_q   <= 1'b0;
			swapped_q   <= 1'b0;
			sort_desc_q <= 1'b1;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			rkey_q      <= '0;
			rsize_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			carry_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				sort_desc_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q  <= STAT_OK;
						rkey_q    <= '0;
						rsize_q   <= '0;
						rd_idx_q  <= '0;
						vld_s1    <= 1'b0;
						sort_en_q <= 1'b0;
						swapped_q <= 1'b0;
						min_q     <= '0;
						max_q     <= '0;
						state_q   <= S_PASS;
						case (opcode_t'(opcode))
							OP_ADD: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							OP_REMOVE: begin
								if (pos_ok) begin
									rd_idx_q <= CW'(pos_ext + PCW'(1));
									state_q  <= S_SHIFT;
								end else begin
									status_q <= STAT_RANGE;
								end
							end
							OP_READ: begin
								if (pos_ok) begin
									state_q <= S_READ;
								end else begin
									status_q <= STAT_RANGE;
								end
							end
							OP_SORT: begin
								sort_en_q <= 1'b1;
							end
							OP_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_READ: begin
					rkey_q  <= rd_entry.key;
					rsize_q <= rd_entry.size;
					state_q <= S_PASS;
				end
				S_SHIFT: begin
					if (rd_idx_q < cnt_q) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q[AW-1:0];
						rd_idx_q <= rd_idx_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
					end
					if (scan_end) begin
						cnt_q     <= last_cnt;
						rd_idx_q  <= '0;
						sort_en_q <= 1'b1;
						state_q   <= S_PASS;
					end
				end
				S_PASS: begin
					if (rd_idx_q < cnt_q) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q[AW-1:0];
						rd_idx_q <= rd_idx_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (idx_s1 == '0) begin
							carry_q <= rd_entry;
							min_q   <= rd_entry.key;
							max_q   <= rd_entry.key;
						end else begin
							if (rd_entry.key < min_q) begin
								min_q <= rd_entry.key;
							end
							if (rd_entry.key > max_q) begin
								max_q <= rd_entry.key;
							end
							if (sort_en_q && do_swap) begin
								swapped_q <= 1'b1;
							end else begin
								carry_q <= rd_entry;
							end
						end
					end
					if (scan_end) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (sort_en_q && swapped_q) begin
						rd_idx_q  <= '0;
						vld_s1    <= 1'b0;
						swapped_q <= 1'b0;
						min_q     <= '0;
						max_q     <= '0;
						state_q   <= S_PASS;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	// order may only change between commands
	assign cfg_ready   = !busy;
	assign done        = done_q;
	assign status      = status_q;
	assign read_key    = rkey_q;
	assign read_size   = rsize_q;
	assign entry_count = COUNT_W'(cnt_q);
	assign min_key     = min_q;
	assign max_key     = max_q;

	`SKT_ASSERT_NEXT(a_accept_busy, accept, busy)
	`SKT_ASSERT_SAME(a_done_idle, done_q, state_q == S_IDLE)
	`SKT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH))
	`SKT_ASSERT_SAME(a_wr_in_range, ram_we && state_q != S_IDLE, CW'(ram_waddr) < cnt_q)
	`SKT_ASSERT_SAME(a_full_status, done_q && status_q == STAT_FULL, full)

endmodule

`default_nettype wire
